### hdl/uer_pkg.sv
// Package for the ultrasonic echo ranger: phase and sequencer enums,
// register indexes, field widths and the pulse timing constants.
// No dependencies; compile first.
package uer_pkg;

    localparam int unsigned TICK_W = 16;
    localparam int unsigned DIST_W = 15;
    localparam int unsigned DIV_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] PRE_LOW_TICKS = 16'd2;
    localparam logic [TICK_W-1:0] HIGH_TICKS    = 16'd10;
    localparam logic [TICK_W-1:0] CNT_MAX       = 16'hFFFF;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20000;
    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 8'd28;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_PIN = 2'd2;

    // Number of quotient bits produced by the divider, one per cycle.
    localparam int unsigned DIV_STEPS = TICK_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_LOW,
        PH_HIGH,
        PH_WAIT,
        PH_MEASURE
    } phase_t;

    typedef enum logic [1:0] {
        SQ_TAKE,
        SQ_DIV,
        SQ_SEND
    } seq_t;

endpackage

### hdl/uer_if.sv
// Handshake channels of the ultrasonic echo ranger: tick input, result
// output and configuration write. Depends on uer_pkg.
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface uer_result_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger_level;
    logic                        trigger_drive;
    logic                        busy_res;
    logic                        done_res;
    logic [uer_pkg::DIST_W-1:0]  distance;

    modport source (output valid, output trigger_level, output trigger_drive,
                    output busy_res, output done_res, output distance, input ready);
    modport sink   (input valid, input trigger_level, input trigger_drive,
                    input busy_res, input done_res, input distance, output ready);
endinterface

interface uer_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [uer_pkg::CFG_IDX_W-1:0]  index;
    logic [uer_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: trigger pulse timing, echo
// timing and a restoring divider for the distance.
// Depends on uer_pkg and the channel interfaces in uer_if.sv.
//
// Usage: every request on the tick channel stands for one microsecond and
// carries the start request and the sampled echo level. Every tick request
// yields exactly one request on the result channel with the trigger level
// and drive, busy, done and the last distance. The configuration channel is
// always ready and writes timeout, divisor and shared-pin mode by index;
// an unknown index is ignored.
// A tick is taken and its result is offered in the next cycle. On the tick
// that finishes a measurement the 16-bit by 8-bit restoring divider, one
// quotient bit per cycle, runs in between, before the result is offered.
// The block takes one tick at a time: tick.ready is high only while no
// tick is being processed. If the receiver stalls, the result is held in
// its register and no further tick is taken until it has gone.
// Reset clears the phase, counters, distance and sequencer and loads the
// configuration defaults (timeout 20000, divisor 28, dedicated pins).
module ultrasonic_echo_ranger (
    input  logic                 clk,
    input  logic                 rst_n,
    uer_tick_if.sink             tick,
    uer_result_if.source         result,
    uer_cfg_if.sink              cfg
);

    uer_pkg::seq_t                   seq_reg, seq_next;
    uer_pkg::phase_t                 phase_reg, phase_next;
    logic [uer_pkg::TICK_W-1:0]      ticks_reg, ticks_next;
    logic [uer_pkg::DIST_W-1:0]      dist_reg, dist_next;

    logic [uer_pkg::TICK_W-1:0]      timeout_reg;
    logic [uer_pkg::DIV_W-1:0]       divisor_reg;
    logic                            shared_reg;

    logic                            trig_reg, trig_next;
    logic                            drive_reg, drive_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [uer_pkg::TICK_W-1:0]      quo_reg, quo_next;
    logic [uer_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [uer_pkg::DIV_W-1:0]       dvs_reg, dvs_next;
    logic [uer_pkg::STEP_W-1:0]      step_reg, step_next;

    // Tick evaluation
    logic                            take;
    uer_pkg::phase_t                 ph_t;
    logic [uer_pkg::TICK_W-1:0]      pt_t;
    logic [uer_pkg::TICK_W-1:0]      wait_cnt;
    logic                            trig_t, pulse_t, busy_t, done_t;

    // Divider step
    logic [uer_pkg::DIV_W:0]         rem_sh;
    logic [uer_pkg::DIV_W-1:0]       rem_diff;
    logic                            rem_ge;

    assign take         = tick.valid && tick.ready;
    assign tick.ready   = (seq_reg == uer_pkg::SQ_TAKE);
    assign cfg.ready    = 1'b1;

    assign result.valid         = (seq_reg == uer_pkg::SQ_SEND);
    assign result.trigger_level = trig_reg;
    assign result.trigger_drive = drive_reg;
    assign result.busy_res      = busy_reg;
    assign result.done_res      = done_reg;
    assign result.distance      = dist_reg;

    // Phase step for one tick.
    always_comb
    begin
        ph_t     = phase_reg;
        pt_t     = ticks_reg;
        trig_t   = 1'b0;
        pulse_t  = 1'b0;
        busy_t   = 1'b1;
        done_t   = 1'b0;
        wait_cnt = ticks_reg;
        unique case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                busy_t = 1'b0;
                if (tick.start_req)
                begin
                    ph_t    = uer_pkg::PH_PRE_LOW;
                    pt_t    = 16'd1;
                    busy_t  = 1'b1;
                    pulse_t = 1'b1;
                end
            end
            uer_pkg::PH_PRE_LOW:
            begin
                pulse_t = 1'b1;
                if (ticks_reg >= uer_pkg::PRE_LOW_TICKS)
                begin
                    ph_t   = uer_pkg::PH_HIGH;
                    pt_t   = 16'd1;
                    trig_t = 1'b1;
                end
                else
                begin
                    pt_t = ticks_reg + 16'd1;
                end
            end
            uer_pkg::PH_HIGH, uer_pkg::PH_WAIT:
            begin
                if (phase_reg == uer_pkg::PH_HIGH && ticks_reg < uer_pkg::HIGH_TICKS)
                begin
                    pt_t    = ticks_reg + 16'd1;
                    trig_t  = 1'b1;
                    pulse_t = 1'b1;
                end
                else
                begin
                    // The first wait tick follows the pulse at once, with
                    // the elapsed count starting from zero.
                    if (phase_reg == uer_pkg::PH_HIGH)
                    begin
                        wait_cnt = '0;
                    end
                    if (tick.echo_level)
                    begin
                        ph_t = uer_pkg::PH_MEASURE;
                        pt_t = 16'd1;
                    end
                    else if (wait_cnt > timeout_reg || wait_cnt == uer_pkg::CNT_MAX)
                    begin
                        ph_t = uer_pkg::PH_MEASURE;
                        pt_t = '0;
                    end
                    else
                    begin
                        ph_t = uer_pkg::PH_WAIT;
                        pt_t = wait_cnt + 16'd1;
                    end
                end
            end
            uer_pkg::PH_MEASURE:
            begin
                if (tick.echo_level && ticks_reg <= timeout_reg
                    && ticks_reg != uer_pkg::CNT_MAX)
                begin
                    pt_t = ticks_reg + 16'd1;
                end
                else
                begin
                    ph_t   = uer_pkg::PH_IDLE;
                    pt_t   = '0;
                    busy_t = 1'b0;
                    done_t = 1'b1;
                end
            end
            default:
            begin
                ph_t = uer_pkg::PH_IDLE;
                pt_t = '0;
            end
        endcase
    end

    // One restoring division step: bring down the next dividend bit.
    // The remainder stays below the divisor, so the difference fits in 8 bits.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[uer_pkg::TICK_W-1]};
        rem_ge   = (rem_sh >= {1'b0, dvs_reg});
        rem_diff = rem_sh[uer_pkg::DIV_W-1:0] - dvs_reg;
    end

    // Sequencer: next state and register updates.
    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        dist_next  = dist_reg;
        trig_next  = trig_reg;
        drive_next = drive_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        step_next  = step_reg;
        unique case (seq_reg)
            uer_pkg::SQ_TAKE:
            begin
                if (take)
                begin
                    phase_next = ph_t;
                    ticks_next = pt_t;
                    trig_next  = trig_t;
                    drive_next = pulse_t || !shared_reg;
                    busy_next  = busy_t;
                    done_next  = done_t;
                    if (done_t)
                    begin
                        quo_next  = ticks_reg;
                        rem_next  = '0;
                        dvs_next  = (divisor_reg == '0) ? 8'd1 : divisor_reg;
                        step_next = '0;
                        seq_next  = uer_pkg::SQ_DIV;
                    end
                    else
                    begin
                        seq_next = uer_pkg::SQ_SEND;
                    end
                end
            end
            uer_pkg::SQ_DIV:
            begin
                rem_next  = rem_ge ? rem_diff : rem_sh[uer_pkg::DIV_W-1:0];
                quo_next  = {quo_reg[uer_pkg::TICK_W-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == uer_pkg::STEP_W'(uer_pkg::DIV_STEPS - 1))
                begin
                    // Halving the quotient is a drop of its last bit.
                    dist_next = quo_next[uer_pkg::TICK_W-1:1];
                    seq_next  = uer_pkg::SQ_SEND;
                end
            end
            uer_pkg::SQ_SEND:
            begin
                if (result.ready)
                begin
                    seq_next = uer_pkg::SQ_TAKE;
                end
            end
            default:
            begin
                seq_next = uer_pkg::SQ_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= uer_pkg::SQ_TAKE;
            phase_reg <= uer_pkg::PH_IDLE;
            ticks_reg <= '0;
            dist_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            dist_reg  <= dist_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= uer_pkg::TIMEOUT_RESET;
            divisor_reg <= uer_pkg::DIVISOR_RESET;
            shared_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                uer_pkg::CFG_TIMEOUT:    timeout_reg <= cfg.data;
                uer_pkg::CFG_DIVISOR:    divisor_reg <= cfg.data[uer_pkg::DIV_W-1:0];
                uer_pkg::CFG_SHARED_PIN: shared_reg  <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        trig_reg  <= trig_next;
        drive_reg <= drive_next;
        busy_reg  <= busy_next;
        done_reg  <= done_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

endmodule

### test/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for ultrasonic_echo_ranger: drives microsecond ticks,
// predicts every result with an in-bench ranging tracker and checks each one.
// Depends on uer_pkg, the channel interfaces in uer_if.sv and the block itself.
module tb_ultrasonic_echo_ranger;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [uer_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned PULSE_TAIL = 11;

    typedef struct packed {
        logic                       trigger_level;
        logic                       trigger_drive;
        logic                       busy_res;
        logic                       done_res;
        logic [uer_pkg::DIST_W-1:0] distance;
    } reading_t;

    class echo_ranging_tracker;
        logic [uer_pkg::TICK_W-1:0] timeout_ticks;
        logic [uer_pkg::DIV_W-1:0]  unit_divisor;
        logic                       shared_pin;
        uer_pkg::phase_t            phase;
        logic [uer_pkg::TICK_W-1:0] phase_ticks;
        logic [uer_pkg::DIST_W-1:0] last_distance;
        reading_t                   expected_readings[$];
        int                         mismatches;

        function new();
            timeout_ticks = uer_pkg::TIMEOUT_RESET;
            unit_divisor  = uer_pkg::DIVISOR_RESET;
            shared_pin    = 1'b0;
            phase         = uer_pkg::PH_IDLE;
            phase_ticks   = '0;
            last_distance = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [uer_pkg::CFG_IDX_W-1:0] reg_index,
                                logic [uer_pkg::CFG_DATA_W-1:0] data);
            unique case (reg_index)
                uer_pkg::CFG_TIMEOUT:    timeout_ticks = data;
                uer_pkg::CFG_DIVISOR:    unit_divisor = data[uer_pkg::DIV_W-1:0];
                uer_pkg::CFG_SHARED_PIN: shared_pin = data[0];
                default:                 ;
            endcase
        endfunction

        function void take_tick(logic start, logic echo);
            reading_t r;
            logic     pulse;
            int       divisor;
            r = '0;
            r.busy_res = 1'b1;
            pulse = 1'b0;
            // The tick after the last high tick is already the first echo-wait tick.
            if (phase == uer_pkg::PH_HIGH && phase_ticks >= uer_pkg::HIGH_TICKS)
            begin
                phase = uer_pkg::PH_WAIT;
                phase_ticks = '0;
            end
            unique case (phase)
                uer_pkg::PH_IDLE:
                begin
                    r.busy_res = 1'b0;
                    if (start)
                    begin
                        phase = uer_pkg::PH_PRE_LOW;
                        phase_ticks = 16'd1;
                        r.busy_res = 1'b1;
                        pulse = 1'b1;
                    end
                end
                uer_pkg::PH_PRE_LOW:
                begin
                    pulse = 1'b1;
                    if (phase_ticks >= uer_pkg::PRE_LOW_TICKS)
                    begin
                        phase = uer_pkg::PH_HIGH;
                        phase_ticks = 16'd1;
                        r.trigger_level = 1'b1;
                    end
                    else
                    begin
                        phase_ticks++;
                    end
                end
                uer_pkg::PH_HIGH:
                begin
                    phase_ticks++;
                    r.trigger_level = 1'b1;
                    pulse = 1'b1;
                end
                uer_pkg::PH_WAIT:
                begin
                    if (echo)
                    begin
                        phase = uer_pkg::PH_MEASURE;
                        phase_ticks = 16'd1;
                    end
                    else if (phase_ticks > timeout_ticks || phase_ticks == uer_pkg::CNT_MAX)
                    begin
                        phase = uer_pkg::PH_MEASURE;
                        phase_ticks = '0;
                    end
                    else
                    begin
                        phase_ticks++;
                    end
                end
                default:
                begin
                    if (echo && phase_ticks <= timeout_ticks
                        && phase_ticks != uer_pkg::CNT_MAX)
                    begin
                        phase_ticks++;
                    end
                    else
                    begin
                        divisor = (unit_divisor == '0) ? 1 : int'(unit_divisor);
                        last_distance =
                            uer_pkg::DIST_W'((int'(phase_ticks) / divisor) / 2);
                        phase = uer_pkg::PH_IDLE;
                        phase_ticks = '0;
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                    end
                end
            endcase
            r.trigger_drive = pulse || !shared_pin;
            r.distance = last_distance;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result request arrived with no tick outstanding");
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.trigger_level !== want.trigger_level)
            begin
                $error("trigger_level: expected %0d, got %0d",
                       want.trigger_level, got.trigger_level);
                mismatches++;
            end
            if (got.trigger_drive !== want.trigger_drive)
            begin
                $error("trigger_drive: expected %0d, got %0d",
                       want.trigger_drive, got.trigger_drive);
                mismatches++;
            end
            if (got.busy_res !== want.busy_res)
            begin
                $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                mismatches++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                mismatches++;
            end
            if (got.distance !== want.distance)
            begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    uer_tick_if   tick_ch();
    uer_result_if result_ch();
    uer_cfg_if    cfg_ch();

    echo_ranging_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ticks_sent = 0;
    int timeout_now = uer_pkg::TIMEOUT_RESET;

    ultrasonic_echo_ranger DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            tracker.check_reading('{trigger_level: result_ch.trigger_level,
                                    trigger_drive: result_ch.trigger_drive,
                                    busy_res:      result_ch.busy_res,
                                    done_res:      result_ch.done_res,
                                    distance:      result_ch.distance});
        end
    end

    // The tracker is advanced here, on the edge that accepts the request, so that
    // the stimulus can look at the predicted phase as soon as the task returns.
    task automatic send_tick(input logic start, input logic echo);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.start_req  <= start;
        tick_ch.echo_level <= echo;
        do @(posedge clk); while (!tick_ch.ready);
        tracker.take_tick(start, echo);
        ticks_sent++;
    endtask

    task automatic stop_ticks();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
    endtask

    task automatic drain_readings();
        while (tracker.expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // Echo high moves a waiting measurement on and echo low then finishes it.
    task automatic settle_to_idle();
        while (tracker.phase != uer_pkg::PH_IDLE)
            send_tick(1'b0, tracker.phase == uer_pkg::PH_WAIT);
    endtask

    task automatic write_reg_cmd(input logic [uer_pkg::CFG_IDX_W-1:0] reg_index,
                                 input logic [uer_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= reg_index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.write_reg(reg_index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure(input int timeout, input int divisor, input logic shared);
        settle_to_idle();
        stop_ticks();
        drain_readings();
        write_reg_cmd(uer_pkg::CFG_TIMEOUT, uer_pkg::CFG_DATA_W'(timeout));
        write_reg_cmd(uer_pkg::CFG_DIVISOR, uer_pkg::CFG_DATA_W'(divisor));
        write_reg_cmd(uer_pkg::CFG_SHARED_PIN, uer_pkg::CFG_DATA_W'(shared));
        timeout_now = timeout;
    endtask

    task automatic run_measurement(input int wait_len, input int high_len);
        settle_to_idle();
        send_tick(1'b1, 1'($urandom));
        repeat (PULSE_TAIL) send_tick(1'($urandom), 1'($urandom));
        repeat (wait_len) send_tick($urandom_range(7) == 0, 1'b0);
        repeat (high_len) send_tick($urandom_range(7) == 0, 1'b1);
        // A start on the closing tick arrives with done and must be ignored.
        send_tick(1'($urandom), 1'b0);
    endtask

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int phase_start;
        int wait_len;
        int high_len;
        int pick;
        int timeout;
        int divisor;
        logic shared;

        rst_n              = 1'b0;
        tick_ch.valid      = 1'b0;
        tick_ch.start_req  = 1'b0;
        tick_ch.echo_level = 1'b0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = uer_pkg::CFG_TIMEOUT;
        cfg_ch.data        = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle ticks, a pulse with starts arriving while busy, a short
        // echo and a start on the done tick, all with the reset configuration.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        for (int i = 0; i < PULSE_TAIL; i++)
            send_tick(1'b1, 1'(i));
        repeat (3) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);

        // One echo longer than the timeout, with divisor 1, so that the count
        // is cut off at the timeout bound.
        configure(100, 1, 1'b0);
        run_measurement(5, 105);

        for (int p = 0; p < 8; p++)
        begin
            unique case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            if (p == 0)
                timeout = 0;
            else if (p == 1)
                timeout = 65534;
            else if (p == 2)
                timeout = 1;
            else if ($urandom_range(1) == 0)
                timeout = $urandom_range(2, 64);
            else
                timeout = $urandom_range(65, 1000);
            if (p == 0)
                divisor = 255;
            else if (p == 1)
                divisor = 1;
            else if ($urandom_range(1) == 0)
                divisor = $urandom_range(1, 40);
            else
                divisor = $urandom_range(1, 255);
            shared = (p < 4) ? 1'(p) : 1'($urandom_range(1));
            configure(timeout, divisor, shared);
            if (p == 0)
                write_reg_cmd(CFG_UNUSED, uer_pkg::CFG_DATA_W'($urandom));

            phase_start = ticks_sent;
            while (ticks_sent - phase_start < 80)
            begin
                if ($urandom_range(9) < 8)
                begin
                    if (timeout_now <= 300 && $urandom_range(3) == 0)
                        wait_len = timeout_now + $urandom_range(0, 2);
                    else
                        wait_len = $urandom_range(0, (timeout_now < 30) ? timeout_now : 30);
                    pick = $urandom_range(7);
                    if (pick == 0)
                        high_len = $urandom_range(0, 600);
                    else if (pick == 1 && timeout_now <= 300)
                        high_len = timeout_now + $urandom_range(0, 2);
                    else
                        high_len = $urandom_range(0, 40);
                    run_measurement(wait_len, high_len);
                end
                else
                begin
                    // Noise: loose ticks, sometimes cutting a measurement short.
                    repeat ($urandom_range(1, 6))
                        send_tick($urandom_range(3) == 0, 1'($urandom));
                end
            end
        end

        stop_ticks();
        drain_readings();
        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### ultrasonic_echo_ranger.f
hdl/uer_pkg.sv
hdl/uer_if.sv
hdl/ultrasonic_echo_ranger.sv
test/tb_ultrasonic_echo_ranger.sv
